### hdl/sprc_pkg.sv
// Shared constants for the semiprime range checker and its checker.
package sprc_pkg;

    // Width of the candidate field on the input channel.
    localparam int CAND_WIDTH = 16;

    // Default number of candidate bits that take part in the test.
    localparam int VALUE_WIDTH_DEF = 16;

    // First trial divisor and its square.
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

    // Smallest value that can be a semiprime.
    localparam int SMALLEST_SEMIPRIME = 4;

endpackage

### hdl/semiprime_range_checker_top.sv
// Semiprime test by trial division, with a running found flag per interval.
// Values below 4 go straight to the result; larger ones try divisors d = 2, 3, ... while d*d <= n,
// each by a restoring division, and after the smallest divisor is found the same search runs on the cofactor.
// Divisors are tried on n and on the cofactor, each search trying at most about sqrt(n) of them.
// One item at a time: the next is taken the cycle after its result is registered, later on a stall.
// Reset (rst_n, asynchronous, active low) clears the sequencer, found flag and out_valid.
module semiprime_range_checker_top #(
    parameter int VALUE_WIDTH = sprc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sprc_pkg::CAND_WIDTH-1:0] candidate,
    input  logic                           last_of_range,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_semiprime,
    output logic                           any_found,
    output logic                           range_done
);
    import sprc_pkg::*;

    // Divisor width: enough for ceil(sqrt(2^VALUE_WIDTH)) plus headroom.
    localparam int DW   = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW   = 2 * DW;
    localparam int CNTW = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] x_reg;
    logic [DW-1:0]          d_reg;
    logic [SW-1:0]          sq_reg;
    logic [DW:0]            rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic                   phase_b_reg;
    logic                   last_reg;
    logic                   semi_reg;
    logic                   found_reg;
    logic                   out_valid_reg;
    logic                   is_semi_reg;
    logic                   any_reg;
    logic                   done_reg;

    // Candidate reduced to the tested width, zero-extended where needed.
    logic [CAND_WIDTH+VALUE_WIDTH-1:0] cand_wide;
    logic [VALUE_WIDTH-1:0]            n_in;
    assign cand_wide = {{VALUE_WIDTH{1'b0}}, candidate};
    assign n_in      = cand_wide[VALUE_WIDTH-1:0];

    // One restoring divider step: shift in the next dividend bit, subtract if it fits.
    logic [DW:0]   rem_shift;
    logic          rem_ge;
    logic [DW:0]   rem_step;
    assign rem_shift = {rem_reg[DW-1:0], quo_reg[VALUE_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};
    assign rem_step  = rem_ge ? (rem_shift - {1'b0, d_reg}) : rem_shift;

    // Square of the divisor against the value under test.
    logic sq_above;
    assign sq_above = sq_reg > {{(SW - VALUE_WIDTH){1'b0}}, x_reg};

    // Next square: (d + 1)^2 = d^2 + 2d + 1.
    logic [SW-1:0] sq_inc;
    assign sq_inc = sq_reg + {{(SW - DW - 1){1'b0}}, d_reg, 1'b1};

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer, shared divider and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A taken result frees the output register unless a new one lands in the same cycle.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg    <= last_of_range;
                        x_reg       <= n_in;
                        d_reg       <= DW'(FIRST_DIVISOR);
                        sq_reg      <= SW'(FIRST_SQUARE);
                        phase_b_reg <= 1'b0;
                        semi_reg    <= 1'b0;
                        if (n_in < VALUE_WIDTH'(SMALLEST_SEMIPRIME))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK:
                begin
                    if (sq_above)
                    begin
                        // No divisor left: n is prime, or the cofactor is prime.
                        semi_reg  <= phase_b_reg;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= x_reg;
                        cnt_reg   <= CNTW'(VALUE_WIDTH - 1);
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= {quo_reg[VALUE_WIDTH-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST:
                begin
                    if (rem_reg == '0)
                    begin
                        if (phase_b_reg)
                        begin
                            // Cofactor has a divisor: not a semiprime.
                            semi_reg  <= 1'b0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            // Smallest divisor found; now test the cofactor.
                            x_reg       <= quo_reg;
                            d_reg       <= DW'(FIRST_DIVISOR);
                            sq_reg      <= SW'(FIRST_SQUARE);
                            phase_b_reg <= 1'b1;
                            state_reg   <= ST_CHECK;
                        end
                    end
                    else
                    begin
                        d_reg     <= d_reg + 1'b1;
                        sq_reg    <= sq_inc;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        is_semi_reg   <= semi_reg;
                        any_reg       <= found_reg | semi_reg;
                        done_reg      <= last_reg;
                        found_reg     <= last_reg ? 1'b0 : (found_reg | semi_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign is_semiprime = is_semi_reg;
    assign any_found    = any_reg;
    assign range_done   = done_reg;

endmodule

### hdl/sprc_checker.sv
// Port-level checks for the semiprime range checker, bound to the top level.
module sprc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [sprc_pkg::CAND_WIDTH-1:0] candidate,
    input logic                           last_of_range,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           is_semiprime,
    input logic                           any_found,
    input logic                           range_done
);
    import sprc_pkg::*;

    // Expected found flag carried from earlier results of the interval.
    logic carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            carry_reg <= range_done ? 1'b0 : any_found;
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({is_semiprime, any_found, range_done}))
        else $error("result changed while stalled");

    // A semiprime verdict always raises the found flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!is_semiprime || any_found))
        else $error("semiprime reported without found flag");

    // The found flag follows earlier results and clears after the interval's last item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_found == (is_semiprime || carry_reg)))
        else $error("found flag does not match interval history");

    // The block takes one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while busy");

endmodule

bind semiprime_range_checker_top sprc_checker u_sprc_checker (.*);
